@@ hw/rtl/apc_passthrough_wrapper_core_assert.svh @@
// assertion macros for the checker file
`ifndef APC_PASSTHROUGH_WRAPPER_CORE_ASSERT_SVH
`define APC_PASSTHROUGH_WRAPPER_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define APC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define APC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/apc_pkg.sv @@
// shared types, codes and byte tables of the apc passthrough wrapper
package apc_pkg;

	localparam logic [7:0] ESC_CODE = 8'h1B;
	localparam logic [7:0] APC_MID  = 8'h5F;
	localparam logic [7:0] APC_LAST = 8'h47;
	localparam logic [7:0] ST_LAST  = 8'h5C;

	// default depth of the command queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// sequence counter in the back end, wide enough for the opener
	localparam int SEQ_IDX_W = 4;
	localparam logic [SEQ_IDX_W-1:0] OPEN_LEN  = SEQ_IDX_W'(11);
	localparam logic [SEQ_IDX_W-1:0] CLOSE_LEN = SEQ_IDX_W'(3);

	// matcher phase
	typedef enum logic [2:0] {
		PH_IDLE,
		PH_ESC,
		PH_ESCU,
		PH_IN,
		PH_IN_ESC
	} phase_t;

	// command kinds handed from front to back
	typedef enum logic [1:0] {
		CMD_OPEN,
		CMD_BODY,
		CMD_CLOSE
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic [7:0] data;
		logic       unterm;
	} cmd_t;

	// opener: prefix ESC P t m u x ; then ESC ESC _ G
	function automatic logic [7:0] open_byte(input logic [SEQ_IDX_W-1:0] idx);
		logic [7:0] b;
		case (idx)
			4'd0:    b = ESC_CODE;
			4'd1:    b = 8'h50;
			4'd2:    b = 8'h74;
			4'd3:    b = 8'h6D;
			4'd4:    b = 8'h75;
			4'd5:    b = 8'h78;
			4'd6:    b = 8'h3B;
			4'd7:    b = ESC_CODE;
			4'd8:    b = ESC_CODE;
			4'd9:    b = APC_MID;
			default: b = APC_LAST;
		endcase
		return b;
	endfunction

	// closer: the received backslash, then ESC backslash
	function automatic logic [7:0] close_byte(input logic [SEQ_IDX_W-1:0] idx);
		logic [7:0] b;
		case (idx)
			4'd1:    b = ESC_CODE;
			default: b = ST_LAST;
		endcase
		return b;
	endfunction

endpackage

@@ hw/rtl/apc_passthrough_wrapper_core.sv @@
// top level of the apc passthrough wrapper
//
// Input channel in_valid/in_stall carries in_byte and in_end; output channel
// out_valid/out_stall carries out_byte, out_last and unterminated. A transfer
// happens on a rising edge with valid high and stall low.
// The front end matches ESC _ G ... ESC backslash sequences and drops bytes
// outside them; each byte inside a sequence becomes a command in a queue of
// QueueDepth entries. The back end turns each command into 1 to 11 output
// bytes at one byte per cycle while out_stall is low: 11 for the opener, 2
// for a doubled ESC, 3 for the closing backslash, 1 otherwise.
// The first result of an input is stored in the queue, then in the output
// register. Throughput: one input per cycle while out_stall is low and each
// input expands to at most one byte; longer expansions are set by the
// one-byte output register and back up into the queue, raising in_stall when
// it is full.
// out_last marks the last byte of each input; unterminated is set on it when
// in_end arrives inside an open sequence.
// Reset clears the matcher to idle and empties queue and output register.
// While out_stall is high a valid output payload holds and the queue fills.
module apc_passthrough_wrapper_core #(
	parameter int QueueDepth = apc_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       in_end,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       out_last,
	output logic       unterminated
);
	import apc_pkg::*;

	cmd_t push_cmd;
	cmd_t head;
	logic push;
	logic pop;
	logic empty;
	logic full;

	// matcher and classifier
	apc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_byte  (in_byte),
		.in_end   (in_end),
		.full     (full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	// command queue
	apc_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.empty    (empty),
		.full     (full)
	);

	// byte expander and output register
	apc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.empty        (empty),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_byte     (out_byte),
		.out_last     (out_last),
		.unterminated (unterminated)
	);

endmodule

@@ hw/rtl/apc_front.sv @@
// front end: sequence matcher that turns input bytes into commands
module apc_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic [7:0]    in_byte,
	input  logic          in_end,
	input  logic          full,
	output logic          push,
	output apc_pkg::cmd_t push_cmd
);
	import apc_pkg::*;

	phase_t phase_q;
	phase_t phase_next;
	logic   accept;
	logic   emit;

	// take a byte whenever the queue has room
	assign in_stall = full;
	assign accept   = in_valid & ~full;
	assign push     = accept & emit;

	// next phase
	always_comb begin
		phase_next = phase_q;
		unique case (phase_q)
			PH_ESC: begin
				if (in_byte == APC_MID) begin
					phase_next = PH_ESCU;
				end else if (in_byte != ESC_CODE) begin
					phase_next = PH_IDLE;
				end
			end
			PH_ESCU: begin
				if (in_byte == APC_LAST) begin
					phase_next = PH_IN;
				end else if (in_byte == ESC_CODE) begin
					phase_next = PH_ESC;
				end else begin
					phase_next = PH_IDLE;
				end
			end
			PH_IN: begin
				if (in_byte == ESC_CODE) begin
					phase_next = PH_IN_ESC;
				end
			end
			PH_IN_ESC: begin
				if (in_byte == ST_LAST) begin
					phase_next = PH_IDLE;
				end else if (in_byte != ESC_CODE) begin
					phase_next = PH_IN;
				end
			end
			default: begin
				phase_next = (in_byte == ESC_CODE) ? PH_ESC : PH_IDLE;
			end
		endcase
	end

	// command for the back end
	always_comb begin
		emit            = 1'b0;
		push_cmd.kind   = CMD_BODY;
		push_cmd.data   = in_byte;
		push_cmd.unterm = in_end;
		unique case (phase_q)
			PH_ESCU: begin
				if (in_byte == APC_LAST) begin
					emit          = 1'b1;
					push_cmd.kind = CMD_OPEN;
				end
			end
			PH_IN: begin
				emit = 1'b1;
			end
			PH_IN_ESC: begin
				emit = 1'b1;
				if (in_byte == ST_LAST) begin
					push_cmd.kind   = CMD_CLOSE;
					push_cmd.unterm = 1'b0;
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	// phase register, end of stream forces idle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
		end else if (accept) begin
			phase_q <= in_end ? PH_IDLE : phase_next;
		end
	end

endmodule

@@ hw/rtl/apc_queue.sv @@
// command queue between front and back end
module apc_queue #(
	parameter int Depth = apc_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  apc_pkg::cmd_t push_cmd,
	input  logic          pop,
	output apc_pkg::cmd_t head,
	output logic          empty,
	output logic          full
);
	import apc_pkg::*;

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	cmd_t            entry_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == CntW'(Depth));
	assign head  = entry_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ hw/rtl/apc_back.sv @@
// back end: expands commands into output bytes, one per cycle unless stalled
module apc_back (
	input  logic          clk,
	input  logic          arst_n,
	input  apc_pkg::cmd_t head,
	input  logic          empty,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [7:0]    out_byte,
	output logic          out_last,
	output logic          unterminated
);
	import apc_pkg::*;

	logic [SEQ_IDX_W-1:0] idx_q;
	logic [SEQ_IDX_W-1:0] len;
	logic [7:0]           next_byte;
	logic                 last_byte;
	logic                 adv;
	logic                 out_valid_q;
	logic [7:0]           out_byte_q;
	logic                 out_last_q;
	logic                 unterm_q;

	// length and byte of the current step
	always_comb begin
		case (head.kind)
			CMD_OPEN: begin
				len       = OPEN_LEN;
				next_byte = open_byte(idx_q);
			end
			CMD_CLOSE: begin
				len       = CLOSE_LEN;
				next_byte = close_byte(idx_q);
			end
			default: begin
				len       = (head.data == ESC_CODE) ? SEQ_IDX_W'(2) : SEQ_IDX_W'(1);
				next_byte = head.data;
			end
		endcase
	end

	assign last_byte = (idx_q == len - 1'b1);
	assign adv       = ~empty & (~out_valid_q | ~out_stall);
	assign pop       = adv & last_byte;

	// step counter within a command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (adv) begin
			idx_q <= last_byte ? '0 : idx_q + 1'b1;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (adv) begin
			out_byte_q <= next_byte;
			out_last_q <= last_byte;
			unterm_q   <= last_byte & head.unterm;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_byte     = out_byte_q;
	assign out_last     = out_last_q;
	assign unterminated = unterm_q;

endmodule

@@ hw/rtl/apc_checker.sv @@
// port-level assertions for the apc passthrough wrapper and their binding
module apc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic [7:0] in_byte,
	input logic       in_end,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_byte,
	input logic       out_last,
	input logic       unterminated
);
`include "apc_passthrough_wrapper_core_assert.svh"

	// a stalled input keeps its payload
	`APC_ASSERT_NEXT(a_in_hold, in_valid && in_stall,
		in_valid && $stable(in_byte) && $stable(in_end),
		"stalled input changed")

	// a stalled output keeps its payload
	`APC_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
		out_valid && $stable(out_byte) && $stable(out_last) && $stable(unterminated),
		"stalled output changed")

	// the flag only rides on the last byte of an input
	`APC_ASSERT_NOW(a_unterm_last, out_valid && unterminated, out_last,
		"unterminated without out_last")

	// a burst, once started, continues without a gap
	`APC_ASSERT_NEXT(a_burst_cont, out_valid && !out_stall && !out_last, out_valid,
		"gap inside an output burst")

endmodule

bind apc_passthrough_wrapper_core apc_checker u_apc_checker (.*);
